// ===== rtl/hti_pkg.sv =====
// ----------------------------------------------------------------------------
// hti_pkg
// Shared widths, codes and types of the Hermite wavetable interpolator.
// ----------------------------------------------------------------------------
package hti_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int FRAC_BITS           = 16;
  localparam int POS_BITS            = 29;
  localparam int ADDR_BITS           = 12;
  localparam int NPOINTS_BITS        = 13;
  localparam int CFG_ADDR_BITS       = 3;
  localparam int CFG_DATA_BITS       = 32;
  localparam int F_BITS              = FRAC_BITS + 1;
  // Horner partial sums stay within 22 times full scale.
  localparam int CALC_BITS           = 22;
  localparam int PROD_BITS           = CALC_BITS + F_BITS + 1;
  localparam int DEFAULT_TABLE_DEPTH = 4096;
  localparam int POINTS_RESET        = 4;
  localparam int MIN_POINTS          = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_POINTS = 1'b0;
  localparam logic REG_VALID  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [F_BITS-1:0] frac;
  } rd_stage_t;

endpackage

// ===== rtl/hermite_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// hermite_table_interpolator
// Wavetable reader with four-point cubic Hermite interpolation.
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ----------------------------------
//   input    in         in_valid / in_stall    opcode, write_address,
//                                              write_value, position
//   output   out        out_valid / out_stall  sample_out (reads only)
//   config   in         APB write/read         points_in_use, table_valid
//
// One transaction is taken every cycle while in_stall is low. A read passes
// through clamp, banked table read, coefficients and three Horner multiply
// stages to the output; a write uses the table slot and yields nothing.
// Each stage holds while the next one is full and stalled, so bubbles close
// up and in_stall rises only when every stage is occupied.
// Reset clears the valid bits and table_valid and sets points_in_use to
// four; the table holds no defined data until written and has no clearing pass.
// ----------------------------------------------------------------------------
module hermite_table_interpolator #(
  parameter int TABLE_DEPTH = hti_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hti_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [hti_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [hti_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [hti_pkg::ADDR_BITS-1:0]        write_address,
  input  hti_pkg::sample_t                     write_value,
  input  logic signed [hti_pkg::POS_BITS-1:0]  position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output hti_pkg::sample_t                     sample_out
);
  import hti_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int RW = (AW > 2) ? AW - 2 : 1;

  logic [NPOINTS_BITS-1:0] points_in_use;
  logic                    table_valid;
  logic                    cfg_write;
  logic                    reg_sel;

  logic              addr_ready;
  logic              table_ready;
  logic              poly_ready;
  logic              a_valid;
  logic              a_read;
  logic              a_zero;
  logic [AW-1:0]     a_idx;
  logic [F_BITS-1:0] a_frac;
  logic              a_wr_ok;
  logic [1:0]        a_wr_bank;
  logic [RW-1:0]     a_wr_row;
  sample_t           a_wr_value;
  rd_stage_t         b_stage;
  logic [3:0][SAMPLE_BITS-1:0] b_samples;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[2];
  assign in_stall  = !addr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= NPOINTS_BITS'(POINTS_RESET);
      table_valid   <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_POINTS: points_in_use <= pwdata[NPOINTS_BITS-1:0];
        REG_VALID:  table_valid   <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POINTS: prdata = CFG_DATA_BITS'(points_in_use);
      REG_VALID:  prdata = CFG_DATA_BITS'(table_valid);
      default:    prdata = '0;
    endcase
  end

  hti_addr #(.TABLE_DEPTH(TABLE_DEPTH)) u_addr (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .opcode        (opcode),
    .write_address (write_address),
    .write_value   (write_value),
    .position      (position),
    .points_in_use (points_in_use),
    .table_valid   (table_valid),
    .down_ready    (table_ready),
    .up_ready      (addr_ready),
    .a_valid       (a_valid),
    .a_read        (a_read),
    .a_zero        (a_zero),
    .a_idx         (a_idx),
    .a_frac        (a_frac),
    .a_wr_ok       (a_wr_ok),
    .a_wr_bank     (a_wr_bank),
    .a_wr_row      (a_wr_row),
    .a_wr_value    (a_wr_value)
  );

  hti_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk        (clk),
    .rst        (rst),
    .a_valid    (a_valid),
    .a_read     (a_read),
    .a_zero     (a_zero),
    .a_idx      (a_idx),
    .a_frac     (a_frac),
    .a_wr_ok    (a_wr_ok),
    .a_wr_bank  (a_wr_bank),
    .a_wr_row   (a_wr_row),
    .a_wr_value (a_wr_value),
    .down_ready (poly_ready),
    .up_ready   (table_ready),
    .b_stage    (b_stage),
    .b_samples  (b_samples)
  );

  hti_poly u_poly (
    .clk        (clk),
    .rst        (rst),
    .b_stage    (b_stage),
    .b_samples  (b_samples),
    .stall      (out_stall),
    .up_ready   (poly_ready),
    .out_valid  (out_valid),
    .sample_out (sample_out)
  );

endmodule

// ===== rtl/hti_addr.sv =====
// ----------------------------------------------------------------------------
// hti_addr
// Input stage: clamps the read position to the usable table span and splits
// the write address into bank and row.
// ----------------------------------------------------------------------------
module hti_addr #(
  parameter  int TABLE_DEPTH = hti_pkg::DEFAULT_TABLE_DEPTH,
  localparam int AW          = $clog2(TABLE_DEPTH),
  localparam int RW          = (AW > 2) ? AW - 2 : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                opcode,
  input  logic [hti_pkg::ADDR_BITS-1:0]       write_address,
  input  hti_pkg::sample_t                    write_value,
  input  logic signed [hti_pkg::POS_BITS-1:0] position,
  input  logic [hti_pkg::NPOINTS_BITS-1:0]    points_in_use,
  input  logic                                table_valid,
  input  logic                                down_ready,
  output logic                                up_ready,
  output logic                                a_valid,
  output logic                                a_read,
  output logic                                a_zero,
  output logic [AW-1:0]                       a_idx,
  output logic [hti_pkg::F_BITS-1:0]          a_frac,
  output logic                                a_wr_ok,
  output logic [1:0]                          a_wr_bank,
  output logic [RW-1:0]                       a_wr_row,
  output hti_pkg::sample_t                    a_wr_value
);
  import hti_pkg::*;

  localparam int DEPTH_BITS = $clog2(TABLE_DEPTH + 1) + 1;
  localparam int IP_BITS    = POS_BITS - FRAC_BITS + 1;
  localparam int IXW        = (DEPTH_BITS > IP_BITS) ? DEPTH_BITS : IP_BITS;

  logic signed [IXW-1:0] ip;
  logic signed [IXW-1:0] npts;
  logic signed [IXW-1:0] max_idx;
  logic signed [IXW-1:0] idx_c;
  logic [F_BITS-1:0]     frac_c;
  logic [31:0]           wa_ext;
  logic                  wr_ok_c;

  assign up_ready = !a_valid || down_ready;

  always_comb begin
    ip = IXW'(signed'(position[POS_BITS-1:FRAC_BITS]));
    priority if (points_in_use < NPOINTS_BITS'(MIN_POINTS)) begin
      npts = IXW'(MIN_POINTS);
    end else if (IXW'(points_in_use) > IXW'(TABLE_DEPTH)) begin
      npts = IXW'(TABLE_DEPTH);
    end else begin
      npts = IXW'(points_in_use);
    end
    max_idx = npts - IXW'(3);
    // Below the first full neighborhood the read sits on entry one; past the
    // end it lands exactly on the third neighbor.
    priority if (ip < IXW'(1)) begin
      idx_c  = IXW'(1);
      frac_c = '0;
    end else if (ip > max_idx) begin
      idx_c  = max_idx;
      frac_c = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      idx_c  = ip;
      frac_c = {1'b0, position[FRAC_BITS-1:0]};
    end
    wa_ext  = 32'(write_address);
    wr_ok_c = wa_ext < 32'(TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (up_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      a_read     <= (opcode == OP_READ);
      a_zero     <= !table_valid;
      a_idx      <= idx_c[AW-1:0];
      a_frac     <= frac_c;
      a_wr_ok    <= wr_ok_c;
      a_wr_bank  <= write_address[1:0];
      a_wr_row   <= wa_ext[RW+1:2];
      a_wr_value <= write_value;
    end
  end

  a_idx_in_span: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_read |-> (a_idx >= AW'(1)) && (32'(a_idx) <= 32'(TABLE_DEPTH - 3)))
    else $error("clamped read index left the usable table span");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    a_valid && !down_ready |=> a_valid && $stable(a_idx) && $stable(a_frac))
    else $error("input stage changed while held");

endmodule

// ===== rtl/hti_table.sv =====
// ----------------------------------------------------------------------------
// hti_table
// Sample table split into four interleaved banks, so the four neighbors of
// a read come out of four bank reads, one per bank, in the same cycle.
// ----------------------------------------------------------------------------
module hti_table #(
  parameter  int TABLE_DEPTH = hti_pkg::DEFAULT_TABLE_DEPTH,
  localparam int AW          = $clog2(TABLE_DEPTH),
  localparam int RW          = (AW > 2) ? AW - 2 : 1
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    a_valid,
  input  logic                                    a_read,
  input  logic                                    a_zero,
  input  logic [AW-1:0]                           a_idx,
  input  logic [hti_pkg::F_BITS-1:0]              a_frac,
  input  logic                                    a_wr_ok,
  input  logic [1:0]                              a_wr_bank,
  input  logic [RW-1:0]                           a_wr_row,
  input  hti_pkg::sample_t                        a_wr_value,
  input  logic                                    down_ready,
  output logic                                    up_ready,
  output hti_pkg::rd_stage_t                      b_stage,
  output logic [3:0][hti_pkg::SAMPLE_BITS-1:0]    b_samples
);
  import hti_pkg::*;

  localparam int BANK_DEPTH = (TABLE_DEPTH + 3) / 4;

  logic [AW-1:0]         base;
  logic [AW+1:0]         base_ext;
  logic [RW-1:0]         base_row;
  logic [3:0][RW-1:0]    rd_row;
  logic                  wr_en;
  logic                  b_valid;
  logic                  b_zero;
  logic [F_BITS-1:0]     b_frac;
  logic [1:0]            b_rot;
  wire  [3:0][SAMPLE_BITS-1:0] rd_word;

  assign up_ready = !b_valid || down_ready;
  assign wr_en    = up_ready && a_valid && !a_read && a_wr_ok;

  // Entries base .. base+3 fall into the four banks; banks below the base's
  // own bank take the next row.
  always_comb begin
    base     = a_idx - AW'(1);
    base_ext = {2'b00, base};
    base_row = base_ext[RW+1:2];
    for (int k = 0; k < 4; k++) begin
      rd_row[k] = (2'(k) < base[1:0]) ? base_row + RW'(1) : base_row;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [BANK_DEPTH];
    logic [SAMPLE_BITS-1:0] rdata;

    always_ff @(posedge clk) begin
      if (wr_en && (a_wr_bank == 2'(k))) begin
        mem[a_wr_row] <= a_wr_value;
      end
      if (up_ready) begin
        rdata <= mem[rd_row[k]];
      end
    end

    assign rd_word[k] = rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (up_ready) begin
      b_valid <= a_valid && a_read;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      b_zero <= a_zero;
      b_frac <= a_frac;
      b_rot  <= base[1:0];
    end
  end

  always_comb begin
    b_stage = '{valid: b_valid, zero: b_zero, frac: b_frac};
    for (int j = 0; j < 4; j++) begin
      b_samples[j] = rd_word[b_rot + 2'(j)];
    end
  end

endmodule

// ===== rtl/hti_poly.sv =====
// ----------------------------------------------------------------------------
// hti_poly
// Coefficient stage and three Horner stages, one multiplier each, ending in
// the saturating output register.
// ----------------------------------------------------------------------------
module hti_poly (
  input  logic                                 clk,
  input  logic                                 rst,
  input  hti_pkg::rd_stage_t                   b_stage,
  input  logic [3:0][hti_pkg::SAMPLE_BITS-1:0] b_samples,
  input  logic                                 stall,
  output logic                                 up_ready,
  output logic                                 out_valid,
  output hti_pkg::sample_t                     sample_out
);
  import hti_pkg::*;

  typedef logic signed [CALC_BITS-1:0] calc_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [F_BITS:0]      frac_s_t;

  localparam calc_t SMAX = calc_t'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam calc_t SMIN = calc_t'(-(2 ** (SAMPLE_BITS - 1)));

  logic ready_d;
  logic ready_e;
  logic ready_f;

  // Coefficient stage.
  logic              c_valid;
  logic              c_zero;
  logic [F_BITS-1:0] c_frac;
  sample_t           c_b;
  calc_t             c_a1;
  calc_t             c_a2;
  calc_t             c_a3;
  calc_t             sa;
  calc_t             sb;
  calc_t             sc;
  calc_t             sd;

  // First and second Horner steps.
  logic              d_valid;
  logic              d_zero;
  logic [F_BITS-1:0] d_frac;
  sample_t           d_b;
  calc_t             d_a1;
  calc_t             d_t;
  logic              e_valid;
  logic              e_zero;
  logic [F_BITS-1:0] e_frac;
  sample_t           e_b;
  calc_t             e_t;

  prod_t prod_d;
  prod_t prod_e;
  prod_t prod_f;
  calc_t t3;
  calc_t r;
  sample_t r_sat;

  assign ready_f  = !out_valid || !stall;
  assign ready_e  = !e_valid || ready_f;
  assign ready_d  = !d_valid || ready_e;
  assign up_ready = !c_valid || ready_d;

  always_comb begin
    sa = calc_t'(signed'(b_samples[0]));
    sb = calc_t'(signed'(b_samples[1]));
    sc = calc_t'(signed'(b_samples[2]));
    sd = calc_t'(signed'(b_samples[3]));
  end

  always_comb begin
    prod_d = c_a3 * frac_s_t'({1'b0, c_frac});
    prod_e = d_t * frac_s_t'({1'b0, d_frac});
    prod_f = e_t * frac_s_t'({1'b0, e_frac});
    t3     = calc_t'(prod_f >>> FRAC_BITS);
    r      = calc_t'(e_b) + (t3 >>> 1);
    priority if (e_zero) begin
      r_sat = '0;
    end else if (r > SMAX) begin
      r_sat = SAMPLE_BITS'(SMAX);
    end else if (r < SMIN) begin
      r_sat = SAMPLE_BITS'(SMIN);
    end else begin
      r_sat = SAMPLE_BITS'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        c_valid <= b_stage.valid;
      end
      if (ready_d) begin
        d_valid <= c_valid;
      end
      if (ready_e) begin
        e_valid <= d_valid;
      end
      if (ready_f) begin
        out_valid <= e_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      c_zero <= b_stage.zero;
      c_frac <= b_stage.frac;
      c_b    <= sample_t'(b_samples[1]);
      c_a1   <= sc - sa;
      c_a2   <= (sa <<< 1) - ((sb <<< 2) + sb) + (sc <<< 2) - sd;
      c_a3   <= sd - sa + ((sb <<< 1) + sb) - ((sc <<< 1) + sc);
    end
    if (ready_d) begin
      d_zero <= c_zero;
      d_frac <= c_frac;
      d_b    <= c_b;
      d_a1   <= c_a1;
      d_t    <= calc_t'(prod_d >>> FRAC_BITS) + c_a2;
    end
    if (ready_e) begin
      e_zero <= d_zero;
      e_frac <= d_frac;
      e_b    <= d_b;
      e_t    <= calc_t'(prod_e >>> FRAC_BITS) + d_a1;
    end
    if (ready_f) begin
      sample_out <= r_sat;
    end
  end

  e_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    e_valid && !ready_f |=> e_valid && $stable(e_t) && $stable(e_b))
    else $error("last Horner stage changed while the output was held");

  zero_when_detached: assert property (@(posedge clk) disable iff (rst)
    ready_f && e_valid && e_zero |=> out_valid && (sample_out == '0))
    else $error("read without an attached table gave a nonzero sample");

  d_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    d_valid && !ready_e |=> d_valid && $stable(d_t))
    else $error("first Horner stage changed while held");

endmodule

// ===== sim/interp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interp_checker
// Tracks the register writes and the table writes of the Hermite wavetable
// interpolator, predicts the sample that each accepted read must produce,
// and compares the samples accepted on the output channel in order.
// ----------------------------------------------------------------------------
module interp_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hti_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [hti_pkg::CFG_DATA_BITS-1:0]   pwdata,
  input  logic                                pready,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                opcode,
  input  logic [hti_pkg::ADDR_BITS-1:0]       write_address,
  input  hti_pkg::sample_t                    write_value,
  input  logic signed [hti_pkg::POS_BITS-1:0] position,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  hti_pkg::sample_t                    sample_out,
  output int unsigned                         failures,
  output int unsigned                         outstanding
);
  import hti_pkg::*;

  sample_t                 wave_table [DEFAULT_TABLE_DEPTH];
  logic [NPOINTS_BITS-1:0] points_reg;
  logic                    attached;
  sample_t                 expected_samples [$];
  sample_t                 oldest;

  // Cubic Hermite sample at a read position, using the current registers
  // and table contents.
  function automatic sample_t interpolate_sample(input logic signed [POS_BITS-1:0] pos);
    longint span, whole, frac, a, b, c, d, lin, quad, cub, acc, top, bottom;
    if (!attached) return '0;
    top    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    bottom = -(longint'(1) << (SAMPLE_BITS - 1));
    span   = longint'(points_reg);
    if (span < MIN_POINTS) span = MIN_POINTS;
    if (span > DEFAULT_TABLE_DEPTH) span = DEFAULT_TABLE_DEPTH;
    whole = longint'(pos) >>> FRAC_BITS;
    frac  = longint'(pos[FRAC_BITS-1:0]);
    if (whole < 1) begin
      whole = 1;
      frac  = 0;
    end else if (whole > span - 3) begin
      // Past the end the curve is pinned to the entry after the last index.
      whole = span - 3;
      frac  = longint'(1) << FRAC_BITS;
    end
    a = wave_table[whole - 1];
    b = wave_table[whole];
    c = wave_table[whole + 1];
    d = wave_table[whole + 2];
    lin  = c - a;
    quad = 2 * a - 5 * b + 4 * c - d;
    cub  = d - a + 3 * b - 3 * c;
    acc  = ((cub * frac) >>> FRAC_BITS) + quad;
    acc  = ((acc * frac) >>> FRAC_BITS) + lin;
    acc  = (acc * frac) >>> FRAC_BITS;
    acc  = b + (acc >>> 1);
    if (acc > top) acc = top;
    if (acc < bottom) acc = bottom;
    return sample_t'(acc);
  endfunction

  task automatic note_failure(input string line);
    failures++;
    if (failures <= 10) $display("%s", line);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_samples.delete();
      points_reg = NPOINTS_BITS'(POINTS_RESET);
      attached   = 1'b0;
      failures   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_POINTS, 2'b00}) begin
          points_reg = pwdata[NPOINTS_BITS-1:0];
        end else if (paddr == {REG_VALID, 2'b00}) begin
          attached = pwdata[0];
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          note_failure($sformatf("checker: sample %0d with none expected at %0t",
                                 sample_out, $time));
        end else begin
          oldest = expected_samples.pop_front();
          if (sample_out !== oldest) begin
            note_failure($sformatf("checker: sample_out expected %0d got %0d at %0t",
                                   oldest, sample_out, $time));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (opcode == OP_READ) begin
          expected_samples.push_back(interpolate_sample(position));
        end else begin
          wave_table[write_address] = write_value;
        end
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Hermite wavetable interpolator. Directed
// reads hit the clamps at both ends and the saturation of the cubic, then
// random mixes of table writes and reads run under several register
// settings with random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
module tb;
  import hti_pkg::*;

  localparam int SETTLE_CYCLES = 16;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]    paddr = '0;
  logic [CFG_DATA_BITS-1:0]    pwdata = '0;
  logic [CFG_DATA_BITS-1:0]    prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        opcode = OP_WRITE;
  logic [ADDR_BITS-1:0]        write_address = '0;
  sample_t                     write_value = '0;
  logic signed [POS_BITS-1:0]  position = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  sample_t                     sample_out;
  int unsigned                 failures;
  int unsigned                 outstanding;
  int unsigned                 filled = 0;

  hermite_table_interpolator dut (.*);
  interp_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic sample_t random_sample();
    unique case ($urandom_range(0, 7))
      0: return sample_t'(16'h7FFF);
      1: return sample_t'(16'h8000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Output back-pressure: quiet stretches, some of them long, between stalls.
  initial begin
    int unsigned quiet, hold;
    forever begin
      quiet = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (quiet) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic op, input logic [ADDR_BITS-1:0] addr,
                           input sample_t value, input logic signed [POS_BITS-1:0] pos,
                           input bit gaps);
    int unsigned gap;
    in_valid      <= 1'b1;
    opcode        <= op;
    write_address <= addr;
    write_value   <= value;
    position      <= pos;
    do @(posedge clk); while (in_stall);
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // A trailing write yields no sample, so give it time to leave the pipeline.
  task automatic drain_and_settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input int unsigned points, input logic attach);
    drain_and_settle();
    reg_write(REG_POINTS, points);
    reg_write(REG_VALID, int'(attach));
  endtask

  // Reads must only touch written entries, so the table is filled ahead of
  // any increase of the point count.
  task automatic fill_table(input int unsigned upto);
    for (int unsigned k = filled; k < upto; k++) begin
      send_item(OP_WRITE, ADDR_BITS'(k), random_sample(), POS_BITS'($urandom), 1'b0);
    end
    if (upto > filled) filled = upto;
  endtask

  task automatic random_phase(input int unsigned n_items, input int unsigned points_cfg,
                              input bit gaps);
    int unsigned span, pick;
    logic [ADDR_BITS-1:0] addr;
    logic signed [POS_BITS-1:0] pos;
    span = (points_cfg < MIN_POINTS) ? MIN_POINTS :
           (points_cfg > DEFAULT_TABLE_DEPTH) ? DEFAULT_TABLE_DEPTH : points_cfg;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 59) == 0) wait_drained();
      if ($urandom_range(0, 3) == 0) begin
        addr = ($urandom_range(0, 2) == 0) ? ADDR_BITS'($urandom) :
                                             ADDR_BITS'($urandom_range(0, span - 1));
        send_item(OP_WRITE, addr, random_sample(), POS_BITS'($urandom), gaps);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          pos = {1'b0, 12'($urandom_range(1, span - 3)), 16'($urandom)};
        end else if (pick < 75) begin
          pos = ($urandom_range(0, 1) == 1) ? {13'd0, 16'($urandom)} : {1'b1, 28'($urandom)};
        end else if (pick < 85) begin
          pos = {1'b0, 12'($urandom_range(span - 2, 4095)), 16'($urandom)};
        end else begin
          pos = POS_BITS'($urandom);
        end
        send_item(OP_READ, ADDR_BITS'($urandom), sample_t'($urandom), pos, gaps);
      end
    end
  endtask

  // With counts at or above the table size only the low filled block and the
  // last four entries hold data, so reads stay near the two ends.
  task automatic end_reads();
    logic signed [POS_BITS-1:0] pos;
    send_item(OP_READ, '0, '0, 29'sh0FFD_8000, 1'b1);
    send_item(OP_READ, '0, '0, 29'sh0FFD_0000, 1'b1);
    send_item(OP_READ, '0, '0, 29'sh0FFE_0000, 1'b1);
    send_item(OP_READ, '0, '0, 29'sh0FFF_FFFF, 1'b1);
    send_item(OP_READ, '0, '0, 29'sh0002_3456, 1'b1);
    send_item(OP_READ, '0, '0, 29'sh1F00_0000, 1'b1);
    for (int k = 0; k < 20; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_item(OP_WRITE, ADDR_BITS'($urandom_range(0, filled - 1)), random_sample(),
                  POS_BITS'($urandom), 1'b1);
      end else begin
        pos = {1'b0, 12'($urandom_range(1, filled - 3)), 16'($urandom)};
        send_item(OP_READ, ADDR_BITS'($urandom), sample_t'($urandom), pos, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Alternating full-scale entries plus the last entry, written while no table is attached.
    send_item(OP_WRITE, 12'd0, sample_t'(16'h8000), '0, 1'b0);
    send_item(OP_WRITE, 12'd1, sample_t'(16'h7FFF), '0, 1'b0);
    send_item(OP_WRITE, 12'd2, sample_t'(16'h8000), '0, 1'b0);
    send_item(OP_WRITE, 12'd3, sample_t'(16'h7FFF), '0, 1'b0);
    send_item(OP_WRITE, 12'hFFF, sample_t'(16'h5A5A), '0, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0FFF_FFFF, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh1000_0000, 1'b0);
    filled = 4;

    set_registers(POINTS_RESET, 1'b1);
    send_item(OP_READ, '0, '0, 29'sh0000_0000, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh1000_0000, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0001_0000, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0001_8000, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0001_FFFF, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0002_0000, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0FFF_FFFF, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh1FFF_FFFF, 1'b0);
    send_item(OP_WRITE, 12'd0, sample_t'(-16'sd1000), '0, 1'b0);
    send_item(OP_WRITE, 12'd1, sample_t'(16'sd3000), '0, 1'b0);
    send_item(OP_WRITE, 12'd2, sample_t'(-16'sd2000), '0, 1'b0);
    send_item(OP_WRITE, 12'd3, sample_t'(16'sd500), '0, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0001_4000, 1'b0);
    // A read right behind a write to one of its neighbours.
    send_item(OP_WRITE, 12'd2, sample_t'(16'h7FFF), '0, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0001_C000, 1'b0);
    send_item(OP_READ, '0, '0, 29'sh0001_0001, 1'b0);

    drain_and_settle();
    random_phase(100, POINTS_RESET, 1'b1);
    fill_table(64);
    set_registers(37, 1'b1);
    random_phase(100, 37, 1'b0);
    // A count below the minimum behaves as the minimum.
    set_registers(2, 1'b1);
    random_phase(60, 2, 1'b1);
    // The last entry already holds data; the three before it are added.
    for (int unsigned k = DEFAULT_TABLE_DEPTH - 4; k < DEFAULT_TABLE_DEPTH - 1; k++) begin
      send_item(OP_WRITE, ADDR_BITS'(k), random_sample(), POS_BITS'($urandom), 1'b0);
    end
    set_registers(DEFAULT_TABLE_DEPTH, 1'b1);
    end_reads();
    set_registers(8191, 1'b1);
    end_reads();
    set_registers(300, 1'b0);
    random_phase(60, 300, 1'b1);
    set_registers(64, 1'b1);
    random_phase(100, 64, 1'b1);
    set_registers(5, 1'b1);
    random_phase(60, 5, 1'b1);
    drain_and_settle();

    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hti_pkg.sv
rtl/hti_addr.sv
rtl/hti_table.sv
rtl/hti_poly.sv
rtl/hermite_table_interpolator.sv
sim/interp_checker.sv
sim/tb.sv
